[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define DMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dmc_pkg.sv]
// shared types and constants of the maze carver
`timescale 1ns / 1ps
package dmc_pkg;

	// default geometry limits
	localparam int MAX_COLS_DEF      = 64;
	localparam int MAX_ROWS_DEF      = 32;
	localparam int STACK_ENTRIES_DEF = 2048;

	// widths wide enough for the whole parameter range
	localparam int DIM_W = 9;
	localparam int CRD_W = 8;
	localparam int CELL_W = 5;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_COLS,
		CFG_GRID_ROWS,
		CFG_START_COL,
		CFG_START_ROW
	} cfg_reg_t;

	// register reset values
	localparam logic [6:0] GRID_COLS_RST = 7'd40;
	localparam logic [5:0] GRID_ROWS_RST = 6'd25;

	// cell bits
	localparam logic [CELL_W-1:0] PASS_N       = 5'h01;
	localparam logic [CELL_W-1:0] PASS_E       = 5'h02;
	localparam logic [CELL_W-1:0] PASS_S       = 5'h04;
	localparam logic [CELL_W-1:0] PASS_W       = 5'h08;
	localparam logic [CELL_W-1:0] CELL_VISITED = 5'h10;
	localparam int VISITED_BIT = 4;

	typedef enum logic [1:0] {
		REQ_START,
		REQ_STEP,
		REQ_READ
	} req_t;

	typedef enum logic [2:0] {
		ST_STARTED,
		ST_CARVED,
		ST_BACKTRACKED,
		ST_COMPLETE,
		ST_READ,
		ST_NOT_STARTED
	} status_t;

	typedef enum logic [1:0] {
		DIR_N,
		DIR_E,
		DIR_S,
		DIR_W
	} dir_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_RD_WAIT,
		S_NB,
		S_CHOOSE,
		S_WR_NB,
		S_WR_CUR,
		S_POP,
		S_FIN
	} seq_state_t;

	// effective geometry after clamping
	typedef struct packed {
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] rows;
		logic [2*DIM_W-1:0] area;
		logic [CRD_W-1:0] start_col;
		logic [CRD_W-1:0] start_row;
	} geom_t;

endpackage

[sv/dmc_req_if.sv]
// request channel: valid, ready and the request fields
`timescale 1ns / 1ps
interface dmc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] random_value;
	logic [5:0]  read_col;
	logic [4:0]  read_row;

	modport source (output valid, req_type, random_value, read_col, read_row, input ready);
	modport sink (input valid, req_type, random_value, read_col, read_row, output ready);
endinterface

[sv/dmc_rsp_if.sv]
// response channel: valid, ready and the result fields
`timescale 1ns / 1ps
interface dmc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  top_col;
	logic [4:0]  top_row;
	logic [1:0]  carve_dir;
	logic [4:0]  cell_bits;
	logic [11:0] visited_count;

	modport source (output valid, status, top_col, top_row, carve_dir, cell_bits,
		visited_count, input ready);
	modport sink (input valid, status, top_col, top_row, carve_dir, cell_bits,
		visited_count, output ready);
endinterface

[sv/dmc_ram.sv]
// generic ram, one write port and one registered read port
`timescale 1ns / 1ps
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/dmc_cfg.sv]
// configuration registers and clamped grid geometry
`timescale 1ns / 1ps
module dmc_cfg #(
	parameter int MAX_COLS = dmc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = dmc_pkg::MAX_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output dmc_pkg::geom_t               geom
);
	import dmc_pkg::*;

	logic [6:0] grid_cols_q;
	logic [5:0] grid_rows_q;
	logic [5:0] start_col_q;
	logic [4:0] start_row_q;

	logic [DIM_W-1:0] cols;
	logic [DIM_W-1:0] rows;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_COLS_RST;
			grid_rows_q <= GRID_ROWS_RST;
			start_col_q <= '0;
			start_row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GRID_COLS: grid_cols_q <= cfg_data[6:0];
				CFG_GRID_ROWS: grid_rows_q <= cfg_data[5:0];
				CFG_START_COL: start_col_q <= cfg_data[5:0];
				CFG_START_ROW: start_row_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// clamp the grid size into 1..max
	always_comb begin
		if (grid_cols_q == '0) begin
			cols = DIM_W'(1);
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			cols = DIM_W'(MAX_COLS);
		end else begin
			cols = DIM_W'(grid_cols_q);
		end
		if (grid_rows_q == '0) begin
			rows = DIM_W'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			rows = DIM_W'(MAX_ROWS);
		end else begin
			rows = DIM_W'(grid_rows_q);
		end
	end

	// clamp the start cell into the grid
	always_comb begin
		geom.cols = cols;
		geom.rows = rows;
		geom.area = (2*DIM_W)'(cols) * (2*DIM_W)'(rows);
		geom.start_col = (int'(start_col_q) < int'(cols)) ? CRD_W'(start_col_q)
			: CRD_W'(cols - DIM_W'(1));
		geom.start_row = (int'(start_row_q) < int'(rows)) ? CRD_W'(start_row_q)
			: CRD_W'(rows - DIM_W'(1));
	end

endmodule

[sv/dmc_pick.sv]
// chooses one open neighbour by random value modulo the open count
`timescale 1ns / 1ps
module dmc_pick (
	input  logic [3:0]    avail,
	input  logic [15:0]   rnd,
	output logic          found,
	output dmc_pkg::dir_t dir
);
	import dmc_pkg::*;

	logic [2:0] count;
	logic [1:0] k;
	logic [1:0] seen;
	logic [1:0] sel;
	logic       hit;

	// residue mod 3: base-4 digits all weigh 1 mod 3
	function automatic logic [1:0] mod3(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		mod3 = t[1:0];
	endfunction

	// index among the open neighbours
	always_comb begin
		count = 3'($countones(avail));
		case (count)
			3'd2: k = {1'b0, rnd[0]};
			3'd3: k = mod3(rnd);
			3'd4: k = rnd[1:0];
			default: k = 2'd0;
		endcase
	end

	// k-th open neighbour in north, east, south, west order
	always_comb begin
		seen = '0;
		hit = 1'b0;
		sel = '0;
		for (int i = 0; i < 4; i++) begin
			if (avail[i]) begin
				if (!hit && seen == k) begin
					sel = 2'(i);
					hit = 1'b1;
				end
				seen = seen + 2'd1;
			end
		end
	end

	assign found = |avail;
	assign dir = dir_t'(sel);

endmodule

[sv/dmc_seq.sv]
// carve sequencer around the cell store and the path stack
`timescale 1ns / 1ps
module dmc_seq #(
	parameter int MAX_COLS      = dmc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS      = dmc_pkg::MAX_ROWS_DEF,
	parameter int STACK_ENTRIES = dmc_pkg::STACK_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dmc_pkg::geom_t  geom,
	dmc_req_if.sink         req,
	dmc_rsp_if.source       rsp
);
	import dmc_pkg::*;

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SAW   = $clog2(STACK_ENTRIES);
	localparam int LW    = $clog2(STACK_ENTRIES + 1);
	localparam int VW    = $clog2(CELLS + 1);
	localparam int SW    = RW + CW;
	localparam logic [2:0] NB_LAST = 3'd5;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		cell_addr = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
	endfunction

	function automatic logic [CELL_W-1:0] pass_of(input dir_t d);
		case (d)
			DIR_N: pass_of = PASS_N;
			DIR_E: pass_of = PASS_E;
			DIR_S: pass_of = PASS_S;
			default: pass_of = PASS_W;
		endcase
	endfunction

	function automatic logic [CELL_W-1:0] back_of(input dir_t d);
		case (d)
			DIR_N: back_of = PASS_S;
			DIR_E: back_of = PASS_W;
			DIR_S: back_of = PASS_N;
			default: back_of = PASS_E;
		endcase
	endfunction

	// control state
	seq_state_t       state_q, state_d;
	logic [2:0]       ph_q;
	logic [AW-1:0]    clr_q;
	logic [LW-1:0]    level_q;
	logic [VW-1:0]    visited_q;
	logic             started_q;
	logic             out_valid_q;

	// item payload
	logic [15:0]       rnd_q;
	logic              in_grid_q;
	status_t           status_q;
	dir_t              dir_q;
	logic [CELL_W-1:0] bits_q;
	logic [CW-1:0]     top_col_q, nb_col_q;
	logic [RW-1:0]     top_row_q, nb_row_q;
	logic [CELL_W-1:0] nb_q [0:4];

	// result register
	status_t     out_status_q;
	logic [5:0]  out_top_col_q;
	logic [4:0]  out_top_row_q;
	dir_t        out_dir_q;
	logic [4:0]  out_bits_q;
	logic [11:0] out_visited_q;

	// memory ports
	logic              c_we, c_re;
	logic [AW-1:0]     c_waddr, c_raddr;
	logic [CELL_W-1:0] c_wdata, c_rdata;
	logic              s_we, s_re;
	logic [SAW-1:0]    s_waddr, s_raddr;
	logic [SW-1:0]     s_wdata, s_rdata;

	// derived signals
	logic          accept;
	logic          step_done;
	logic          fin_go;
	logic          rq_in;
	logic [AW-1:0] rq_addr;
	logic [CW-1:0] s_col;
	logic [RW-1:0] s_row;
	logic [AW-1:0] start_addr;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] n_addr, e_addr, so_addr, w_addr, nb_addr;
	logic [3:0]    ex;
	logic [3:0]    avail;
	logic          pick_found;
	dir_t          pick_dir;
	logic          clr_last;
	logic [2:0]    nb_idx;

	dmc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);

	dmc_ram #(.WIDTH(SW), .DEPTH(STACK_ENTRIES)) u_stack_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	dmc_pick u_pick (
		.avail(avail), .rnd(rnd_q), .found(pick_found), .dir(pick_dir)
	);

	// item bookkeeping and addresses
	always_comb begin
		accept = req.valid && req.ready;
		step_done = (int'(visited_q) >= int'(geom.area)) || (level_q == '0);
		fin_go = !out_valid_q || rsp.ready;
		rq_in = (int'(req.read_col) < int'(geom.cols)) && (int'(req.read_row) < int'(geom.rows));
		rq_addr = cell_addr(RW'(req.read_row), CW'(req.read_col));
		s_col = CW'(geom.start_col);
		s_row = RW'(geom.start_row);
		start_addr = cell_addr(s_row, s_col);
		clr_last = (clr_q == AW'(CELLS - 1));
		cur_addr = cell_addr(top_row_q, top_col_q);
		n_addr = cell_addr(top_row_q - RW'(1), top_col_q);
		e_addr = cell_addr(top_row_q, top_col_q + CW'(1));
		so_addr = cell_addr(top_row_q + RW'(1), top_col_q);
		w_addr = cell_addr(top_row_q, top_col_q - CW'(1));
		nb_addr = cell_addr(nb_row_q, nb_col_q);
		nb_idx = 3'(dir_q) + 3'd1;
	end

	// neighbours inside the grid and not yet visited
	always_comb begin
		ex[0] = (top_row_q != '0);
		ex[1] = (int'(top_col_q) + 1) < int'(geom.cols);
		ex[2] = (int'(top_row_q) + 1) < int'(geom.rows);
		ex[3] = (top_col_q != '0);
		for (int i = 0; i < 4; i++) begin
			avail[i] = ex[i] && !nb_q[i + 1][VISITED_BIT];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_START: state_d = S_CLEAR;
						REQ_STEP: state_d = (started_q && !step_done) ? S_NB : S_FIN;
						REQ_READ: state_d = S_RD_WAIT;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_FIN;
				end
			end
			S_RD_WAIT: state_d = S_FIN;
			S_NB: begin
				if (ph_q == NB_LAST) begin
					state_d = S_CHOOSE;
				end
			end
			S_CHOOSE: begin
				if (pick_found) begin
					state_d = S_WR_NB;
				end else if (level_q > LW'(1)) begin
					state_d = S_POP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WR_NB: state_d = S_WR_CUR;
			S_WR_CUR: state_d = S_FIN;
			S_POP: state_d = S_FIN;
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls and ready
	always_comb begin
		req.ready = 1'b0;
		c_we = 1'b0;
		c_waddr = cur_addr;
		c_wdata = '0;
		c_re = 1'b0;
		c_raddr = cur_addr;
		s_we = 1'b0;
		s_waddr = '0;
		s_wdata = {nb_row_q, nb_col_q};
		s_re = 1'b0;
		s_raddr = SAW'(level_q - LW'(2));
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				c_re = accept && (req.req_type == REQ_READ);
				c_raddr = rq_addr;
			end
			S_CLEAR: begin
				c_we = 1'b1;
				c_waddr = clr_q;
				c_wdata = (clr_q == start_addr) ? CELL_VISITED : '0;
				s_we = clr_last;
				s_wdata = {s_row, s_col};
			end
			S_NB: begin
				c_re = (ph_q < NB_LAST);
				case (ph_q)
					3'd1: c_raddr = ex[0] ? n_addr : cur_addr;
					3'd2: c_raddr = ex[1] ? e_addr : cur_addr;
					3'd3: c_raddr = ex[2] ? so_addr : cur_addr;
					3'd4: c_raddr = ex[3] ? w_addr : cur_addr;
					default: c_raddr = cur_addr;
				endcase
			end
			S_CHOOSE: s_re = 1'b1;
			S_WR_NB: begin
				c_we = 1'b1;
				c_waddr = nb_addr;
				c_wdata = nb_q[nb_idx] | back_of(dir_q) | CELL_VISITED;
			end
			S_WR_CUR: begin
				c_we = 1'b1;
				c_wdata = nb_q[0] | pass_of(dir_q);
				s_we = 1'b1;
				s_waddr = (level_q < LW'(STACK_ENTRIES)) ? SAW'(level_q)
					: SAW'(STACK_ENTRIES - 1);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= '0;
			clr_q <= '0;
			level_q <= '0;
			visited_q <= '0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					ph_q <= '0;
					clr_q <= '0;
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_last) begin
						level_q <= LW'(1);
						visited_q <= VW'(1);
						started_q <= 1'b1;
					end
				end
				S_NB: ph_q <= ph_q + 3'd1;
				S_CHOOSE: begin
					if (!pick_found) begin
						level_q <= level_q - LW'(1);
					end
				end
				S_WR_CUR: begin
					if (level_q < LW'(STACK_ENTRIES)) begin
						level_q <= level_q + LW'(1);
					end
					visited_q <= visited_q + VW'(1);
				end
				default: ;
			endcase
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rnd_q <= req.random_value;
					in_grid_q <= rq_in && started_q;
					dir_q <= DIR_N;
					bits_q <= '0;
					case (req.req_type)
						REQ_START: status_q <= ST_STARTED;
						REQ_STEP: status_q <= !started_q ? ST_NOT_STARTED : ST_COMPLETE;
						REQ_READ: status_q <= ST_READ;
						default: status_q <= ST_NOT_STARTED;
					endcase
				end
			end
			S_CLEAR: begin
				if (clr_last) begin
					top_col_q <= s_col;
					top_row_q <= s_row;
				end
			end
			S_RD_WAIT: bits_q <= in_grid_q ? c_rdata : '0;
			S_NB: begin
				if (ph_q != 3'd0) begin
					nb_q[ph_q - 3'd1] <= c_rdata;
				end
			end
			S_CHOOSE: begin
				if (pick_found) begin
					dir_q <= pick_dir;
					status_q <= ST_CARVED;
				end else begin
					status_q <= ST_BACKTRACKED;
				end
				// neighbour coordinates for the chosen direction
				case (pick_dir)
					DIR_N: begin
						nb_col_q <= top_col_q;
						nb_row_q <= top_row_q - RW'(1);
					end
					DIR_E: begin
						nb_col_q <= top_col_q + CW'(1);
						nb_row_q <= top_row_q;
					end
					DIR_S: begin
						nb_col_q <= top_col_q;
						nb_row_q <= top_row_q + RW'(1);
					end
					default: begin
						nb_col_q <= top_col_q - CW'(1);
						nb_row_q <= top_row_q;
					end
				endcase
			end
			S_WR_CUR: begin
				top_col_q <= nb_col_q;
				top_row_q <= nb_row_q;
			end
			S_POP: {top_row_q, top_col_q} <= s_rdata;
			S_FIN: begin
				if (fin_go) begin
					out_status_q <= status_q;
					out_top_col_q <= (level_q != '0) ? 6'(top_col_q) : '0;
					out_top_row_q <= (level_q != '0) ? 5'(top_row_q) : '0;
					out_dir_q <= dir_q;
					out_bits_q <= bits_q;
					out_visited_q <= 12'(visited_q);
				end
			end
			default: ;
		endcase
	end

	// result channel
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.top_col = out_top_col_q;
	assign rsp.top_row = out_top_row_q;
	assign rsp.carve_dir = out_dir_q;
	assign rsp.cell_bits = out_bits_q;
	assign rsp.visited_count = out_visited_q;

endmodule

[sv/dfs_maze_carver_unit.sv]
// Depth-first maze carver, top level.
// A request item on req is start (clear the grid, push the start cell), step
// (carve towards one unvisited neighbour or backtrack) or read (bits of one
// cell). Every item yields one result item on rsp with status, top of stack,
// carve direction, cell bits and visited count.
// Config is a plain write port (cfg_we, cfg_index, cfg_data); write it idle.
// Work per item from the accepted request to the result:
//   read: one cell store read
//   step that carves: five serial reads of the top cell and its
//     four neighbours from the single read port, then two cell writes
//   step that backtracks: one stack read for the new top instead
//     of the two writes; no pop when the stack runs empty
//   step rejected or complete, unknown type: no memory access
//   start: one cell cleared per cycle over all MAX_COLS*MAX_ROWS cells
// One item is in work at a time; the next is taken in the cycle after the
// result is loaded into the output register.
// Reset clears the control state; the cell store is not swept at reset,
// reads before the first start return zero.
// If rsp stalls, a finished result waits in the output register and the
// block holds its final state until that register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfs_maze_carver_unit #(
	parameter int MAX_COLS      = dmc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS      = dmc_pkg::MAX_ROWS_DEF,
	parameter int STACK_ENTRIES = dmc_pkg::STACK_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data,
	dmc_req_if.sink                        req,
	dmc_rsp_if.source                      rsp
);
	import dmc_pkg::*;

	geom_t geom;

	// config registers
	dmc_cfg #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .geom(geom)
	);

	// carve sequencer with cell store and path stack
	dmc_seq #(
		.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .STACK_ENTRIES(STACK_ENTRIES)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .geom(geom), .req(req), .rsp(rsp)
	);

	// checks
	`DMC_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	`DMC_ASSERT_NOW(a_start_count, rsp.valid && rsp.status == ST_STARTED, rsp.visited_count == 12'd1, "start count")
	`DMC_ASSERT_NOW(a_bits_only_read, rsp.valid && rsp.status != ST_READ, rsp.cell_bits == 5'd0, "cell bits")
	`DMC_ASSERT_NOW(a_dir_only_carve, rsp.valid && rsp.status != ST_CARVED, rsp.carve_dir == DIR_N, "carve dir")

endmodule
